FILE: rtl/mbm_pkg.sv
// Shared types and constants for the mode background model.
// Holds field widths, register indexes, FSM states and the control/status
// structs passed between controller and datapath. No dependencies.
package mbm_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int MBM_POSITIONS  = 16384;
  localparam int MBM_MAX_LEVELS = 16;
  localparam int MBM_MAX_FRAMES = 32;

  // Word field widths
  localparam int SAMPLE_W = 8;
  localparam int POSIN_W  = 14;
  localparam int BG_W     = 8;
  localparam int MODE_W   = 4;

  // Histogram counts saturate at COUNT_MAX
  localparam int CNT_W     = 6;
  localparam int COUNT_MAX = 63;

  // Intensity full scale and its half, used for rounding
  localparam int BG_MAX  = 255;
  localparam int HALF_BG = BG_MAX / 2;

  // Configuration register widths and port sizing
  localparam int LC_W       = 5;
  localparam int HF_W       = 6;
  localparam int UI_W       = 8;
  localparam int FSU_MAX    = 255;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_COUNT     = 2'd0,
    CFG_HISTORY_FRAMES  = 2'd1,
    CFG_UPDATE_INTERVAL = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_SCAN,
    ST_DSTART,
    ST_DWAIT,
    ST_DONE
  } mbm_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;     // write a zero row during the clearing pass
    logic take;       // capture the input word, frame bookkeeping
    logic rd;         // read row and background, quantize sample
    logic modify;     // update histogram and ring, write row back
    logic scan;       // compare one bin against the running max
    logic div_start;  // launch background rescale divide
    logic bg_wr;      // store divide result as background
    logic out_load;   // load the output word register
  } mbm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic upd;
    logic scan_last;
    logic div_done;
  } mbm_sts_t;

endpackage

FILE: rtl/mbm_in_if.sv
// Input channel interface: valid/ready handshake plus one sample word.
// Depends on mbm_pkg for field widths.
interface mbm_in_if import mbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [POSIN_W-1:0]  position;
  logic                frame_last;

  modport source (output valid, sample, position, frame_last, input ready);
  modport sink   (input valid, sample, position, frame_last, output ready);
endinterface

FILE: rtl/mbm_out_if.sv
// Result channel interface: valid/ready handshake plus one result word.
// Depends on mbm_pkg for field widths.
interface mbm_out_if import mbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BG_W-1:0]   background;
  logic [MODE_W-1:0] mode_level;
  logic              updated;

  modport source (output valid, background, mode_level, updated, input ready);
  modport sink   (input valid, background, mode_level, updated, output ready);
endinterface

FILE: rtl/mbm_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
// Quotient must fit in Q_W bits (num < den << Q_W). No package dependency.
module mbm_div #(
  parameter int N_W = 13,
  parameter int D_W = 5,
  parameter int Q_W = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [Q_W-1:0] quo,
  output logic           done
);

  localparam int STEP_W = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic [N_W-1:0]    rem_r;
  logic [N_W-1:0]    dsh_r;
  logic [Q_W-1:0]    quo_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic              fits;

  assign fits = (rem_r >= dsh_r);

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(Q_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  // remainder / shifted divisor / quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= N_W'(den) << (Q_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      quo_r <= {quo_r[Q_W-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

FILE: rtl/mbm_dp.sv
// Datapath: config registers, frame bookkeeping, row memory (histogram +
// history ring per position), background memory, quantizer, mode scan and
// the rescale divider. Depends on mbm_pkg and mbm_div.
module mbm_dp import mbm_pkg::*; #(
  parameter int POSITIONS  = MBM_POSITIONS,
  parameter int MAX_LEVELS = MBM_MAX_LEVELS,
  parameter int MAX_FRAMES = MBM_MAX_FRAMES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mbm_cmd_t              cmd,
  output mbm_sts_t              sts,
  input  logic [SAMPLE_W-1:0]   sample,
  input  logic [POSIN_W-1:0]    position,
  input  logic                  frame_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [BG_W-1:0]       background,
  output logic [MODE_W-1:0]     mode_level,
  output logic                  updated
);

  localparam int POS_W    = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int LVL_W    = $clog2(MAX_LEVELS);
  localparam int SLOT_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int HIST_W   = MAX_LEVELS * CNT_W;
  localparam int RING_W   = MAX_FRAMES * LVL_W;
  localparam int ROW_W    = HIST_W + RING_W;
  localparam int Y_W      = SAMPLE_W + LVL_W;
  localparam int D_W      = LVL_W + 1;
  localparam int N_W      = BG_W + D_W;
  localparam int LC_CMP_W = (LVL_W + 1 > LC_W) ? LVL_W + 1 : LC_W;
  localparam int HF_CMP_W = (SLOT_W + 1 > HF_W) ? SLOT_W + 1 : HF_W;

  // ---------------- configuration and frame state ----------------
  logic [LC_W-1:0]   level_count_r;
  logic [HF_W-1:0]   history_frames_r;
  logic [UI_W-1:0]   update_interval_r;
  logic [UI_W-1:0]   fsu_r;
  logic [SLOT_W-1:0] slot_r;
  logic              in_frame_r;
  logic              frame_upd_r;

  // per-word registers
  logic [SAMPLE_W-1:0] sample_r;
  logic [POS_W-1:0]    pos_r;
  logic                upd_r;
  logic [SLOT_W-1:0]   slot_item_r;

  logic [LC_CMP_W-1:0] lc_ext;
  logic [LVL_W-1:0]    k_eff;
  logic [HF_CMP_W-1:0] hf_ext;
  logic [HF_CMP_W-1:0] h_eff;
  logic [HF_CMP_W-1:0] slot_inc;
  logic [SLOT_W-1:0]   slot_next;
  logic [UI_W-1:0]     iv;
  logic                start_upd;
  logic                upd_cur;
  logic [UI_W-1:0]     fsu_after;
  logic [UI_W-1:0]     fsu_end;
  logic [POSIN_W-1:0]  pos_v;
  logic [POS_W-1:0]    pos_red;

  // effective level count, kept as L-1
  always_comb begin
    lc_ext = LC_CMP_W'(level_count_r);
    if (lc_ext < LC_CMP_W'(2)) begin
      k_eff = LVL_W'(1);
    end else if (lc_ext > LC_CMP_W'(MAX_LEVELS)) begin
      k_eff = LVL_W'(MAX_LEVELS - 1);
    end else begin
      k_eff = LVL_W'(lc_ext - LC_CMP_W'(1));
    end
  end

  // effective ring length and slot advance
  always_comb begin
    hf_ext = HF_CMP_W'(history_frames_r);
    if (hf_ext < HF_CMP_W'(1)) begin
      h_eff = HF_CMP_W'(1);
    end else if (hf_ext > HF_CMP_W'(MAX_FRAMES)) begin
      h_eff = HF_CMP_W'(MAX_FRAMES);
    end else begin
      h_eff = hf_ext;
    end
    slot_inc  = HF_CMP_W'(slot_r) + HF_CMP_W'(1);
    slot_next = (slot_inc >= h_eff) ? '0 : SLOT_W'(slot_inc);
  end

  // update decision at frame start; counter bump at frame end
  always_comb begin
    iv        = (update_interval_r == '0) ? UI_W'(1) : update_interval_r;
    start_upd = (fsu_r >= iv);
    upd_cur   = in_frame_r ? frame_upd_r : start_upd;
    fsu_after = (!in_frame_r && start_upd) ? '0 : fsu_r;
    fsu_end   = (fsu_after == UI_W'(FSU_MAX)) ? fsu_after : fsu_after + 1'b1;
  end

  // position modulo POSITIONS: compare-subtract on shifted multiples
  always_comb begin
    pos_v = position;
    for (int i = POSIN_W - 1; i >= 0; i--) begin
      if ((longint'(POSITIONS) << i) < (longint'(1) << POSIN_W)) begin
        if (pos_v >= POSIN_W'(longint'(POSITIONS) << i)) begin
          pos_v = pos_v - POSIN_W'(longint'(POSITIONS) << i);
        end
      end
    end
    pos_red = POS_W'(pos_v);
  end

  // config and frame bookkeeping registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r     <= LC_W'(16);
      history_frames_r  <= HF_W'(32);
      update_interval_r <= UI_W'(1);
      fsu_r             <= UI_W'(1);
      slot_r            <= '0;
      in_frame_r        <= 1'b0;
      frame_upd_r       <= 1'b0;
    end else begin
      if (cmd.take) begin
        frame_upd_r <= upd_cur;
        in_frame_r  <= !frame_last;
        if (frame_last) begin
          fsu_r <= fsu_end;
          if (upd_cur) begin
            slot_r <= slot_next;
          end
        end else begin
          fsu_r <= fsu_after;
        end
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_LEVEL_COUNT:     level_count_r    <= cfg_data[LC_W-1:0];
          CFG_HISTORY_FRAMES:  history_frames_r <= cfg_data[HF_W-1:0];
          CFG_UPDATE_INTERVAL: begin
            update_interval_r <= cfg_data[UI_W-1:0];
            fsu_r             <= cfg_data[UI_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sample_r    <= sample;
      pos_r       <= pos_red;
      upd_r       <= upd_cur;
      slot_item_r <= slot_r;
    end
  end

  // ---------------- quantizer ----------------
  // level = round(s*(L-1)/255); y/255 via (y + 1 + (y >> 8)) >> 8, exact below 2^16
  logic [Y_W-1:0]   y;
  logic [Y_W:0]     q_sum;
  logic [LVL_W:0]   q_full;
  logic [LVL_W-1:0] q_clamp;
  logic [LVL_W-1:0] q_r;

  always_comb begin
    y       = Y_W'(sample_r) * Y_W'(k_eff) + Y_W'(HALF_BG);
    q_sum   = (Y_W + 1)'(y) + (Y_W + 1)'(1) + (Y_W + 1)'(y >> BG_W);
    q_full  = q_sum[Y_W:BG_W];
    q_clamp = (q_full > {1'b0, k_eff}) ? k_eff : q_full[LVL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      q_r <= q_clamp;
    end
  end

  // ---------------- row memory and background memory ----------------
  logic [ROW_W-1:0] row_mem [POSITIONS];
  logic [BG_W-1:0]  bg_mem  [POSITIONS];
  logic [ROW_W-1:0] row_rd_r;
  logic [BG_W-1:0]  bg_rd_r;
  logic [POS_W-1:0] clr_addr_r;
  logic             row_we;
  logic [POS_W-1:0] row_wa;
  logic [ROW_W-1:0] row_wd;
  logic [BG_W-1:0]  div_quo;
  logic             div_done;

  logic [MAX_LEVELS-1:0][CNT_W-1:0] hist_rd;
  logic [MAX_LEVELS-1:0][CNT_W-1:0] hist_new;
  logic [MAX_LEVELS-1:0][CNT_W-1:0] bins_src;
  logic [MAX_FRAMES-1:0][LVL_W-1:0] ring_rd;
  logic [MAX_FRAMES-1:0][LVL_W-1:0] ring_new;
  logic [LVL_W-1:0]                 old_lvl;
  logic [CNT_W-1:0]                 cnt;

  // remove the oldest level, count the new one
  always_comb begin
    hist_rd  = row_rd_r[HIST_W-1:0];
    ring_rd  = row_rd_r[ROW_W-1:HIST_W];
    old_lvl  = ring_rd[slot_item_r];
    ring_new = ring_rd;
    ring_new[slot_item_r] = q_r;
    cnt = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      cnt = hist_rd[i];
      if (LVL_W'(i) == old_lvl && cnt != '0) begin
        cnt = cnt - 1'b1;
      end
      if (LVL_W'(i) == q_r && cnt != CNT_W'(COUNT_MAX)) begin
        cnt = cnt + 1'b1;
      end
      hist_new[i] = cnt;
    end
    bins_src = upd_r ? hist_new : hist_rd;
  end

  assign row_we = cmd.clr_wr || (cmd.modify && upd_r);
  assign row_wa = cmd.clr_wr ? clr_addr_r : pos_r;
  assign row_wd = cmd.clr_wr ? '0 : {ring_new, hist_new};

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (cmd.rd) begin
      row_rd_r <= row_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bg_wr) begin
      bg_mem[pos_r] <= div_quo;
    end
    if (cmd.rd) begin
      bg_rd_r <= bg_mem[pos_r];
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // ---------------- mode scan, one bin per cycle ----------------
  logic [CNT_W-1:0] bins_r [MAX_LEVELS];
  logic [CNT_W-1:0] best_cnt_r;
  logic [LVL_W-1:0] best_idx_r;
  logic [LVL_W-1:0] scan_idx_r;
  logic [BG_W-1:0]  bg_val_r;

  always_ff @(posedge clk) begin
    if (cmd.modify) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        bins_r[i] <= bins_src[i];
      end
      best_cnt_r <= bins_src[0];
      best_idx_r <= '0;
      scan_idx_r <= LVL_W'(1);
      if (!upd_r) begin
        bg_val_r <= bg_rd_r;
      end
    end
    if (cmd.scan) begin
      if (bins_r[scan_idx_r] > best_cnt_r) begin
        best_cnt_r <= bins_r[scan_idx_r];
        best_idx_r <= scan_idx_r;
      end
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    if (cmd.bg_wr) begin
      bg_val_r <= div_quo;
    end
  end

  // ---------------- background rescale: (510*m + k) / 2k ----------------
  logic [N_W-1:0] div_n;
  logic [D_W-1:0] div_d;

  assign div_n = N_W'(best_idx_r) * N_W'(2 * BG_MAX) + N_W'(k_eff);
  assign div_d = {k_eff, 1'b0};

  mbm_div #(
    .N_W(N_W),
    .D_W(D_W),
    .Q_W(BG_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (div_n),
    .den  (div_d),
    .quo  (div_quo),
    .done (div_done)
  );

  // ---------------- output word register ----------------
  logic [BG_W-1:0]   background_r;
  logic [MODE_W-1:0] mode_level_r;
  logic              updated_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      background_r <= bg_val_r;
      mode_level_r <= MODE_W'(best_idx_r);
      updated_r    <= upd_r;
    end
  end

  assign background = background_r;
  assign mode_level = mode_level_r;
  assign updated    = updated_r;

  // status to controller
  always_comb begin
    sts.clr_last  = (clr_addr_r == POS_W'(POSITIONS - 1));
    sts.upd       = upd_r;
    sts.scan_last = (scan_idx_r == k_eff);
    sts.div_done  = div_done;
  end

`ifndef SYNTHESIS
  // the scan never walks past the last effective level
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> scan_idx_r <= k_eff)
    else $error("mode scan index beyond level count");

  // background written only on updating words
  a_bg_wr_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bg_wr |-> upd_r)
    else $error("background written on a skipped frame");
`endif

endmodule

FILE: rtl/mbm_ctrl.sv
// Controller FSM: clearing pass, word sequencing and output register
// handshake. Drives mbm_cmd_t, reads mbm_sts_t. Depends on mbm_pkg.
module mbm_ctrl import mbm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output mbm_cmd_t cmd,
  input  mbm_sts_t sts
);

  mbm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_MODIFY;
      end
      ST_MODIFY: begin
        cmd.modify = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = sts.upd ? ST_DSTART : ST_DONE;
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (sts.div_done) begin
          cmd.bg_wr = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // output word valid: set on load, cleared when taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == ST_READ)
    else $error("accepted word not followed by a row read");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == ST_DWAIT)
    else $error("divider finished outside the wait state");

  a_div_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> sts.upd)
    else $error("rescale launched on a skipped frame");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("output word raised outside the done state");
`endif

endmodule

FILE: rtl/mode_background_model_top.sv
// Channel   | dir | handshake     | word
// in_ch     | in  | valid/ready   | sample[8], position[14], frame_last[1]
// out_ch    | out | valid/ready   | background[8], mode_level[4], updated[1]
// cfg_*     | in  | cfg_we strobe | cfg_index[2], cfg_data[8]
//
// One word at a time: the next word is accepted only once the previous one is in the output
// register. An updating-frame word passes the row read, the modify step, the mode scan
// (one bin per cycle), the bit-serial rescale divider (one quotient bit per cycle) and the
// done state; a skipped-frame word passes the same steps but for the divider.
// After reset a clearing pass writes a zero row to every position with in_ch.ready low;
// config writes are taken throughout. A stalled out_ch holds the next word in its done state.
// Top level of the mode background model; depends on mbm_pkg, the channel
// interfaces, mbm_ctrl, mbm_dp and mbm_div.
module mode_background_model_top import mbm_pkg::*; #(
  parameter int POSITIONS  = MBM_POSITIONS,
  parameter int MAX_LEVELS = MBM_MAX_LEVELS,
  parameter int MAX_FRAMES = MBM_MAX_FRAMES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mbm_in_if.sink                in_ch,
  mbm_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mbm_cmd_t cmd;
  mbm_sts_t sts;

  mbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mbm_dp #(
    .POSITIONS (POSITIONS),
    .MAX_LEVELS(MAX_LEVELS),
    .MAX_FRAMES(MAX_FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (in_ch.sample),
    .position  (in_ch.position),
    .frame_last(in_ch.frame_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .background(out_ch.background),
    .mode_level(out_ch.mode_level),
    .updated   (out_ch.updated)
  );

endmodule

FILE: tb/tb_mode_background_model_top.sv
// Self-checking testbench for mode_background_model_top: directed frames, then random frame traffic.
// Carries its own predictor of the background estimate and compares every result word with it.
// Depends on mbm_pkg, mbm_in_if, mbm_out_if and the top level.
module tb_mode_background_model_top;
  import mbm_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 64;   // idle tail after the last result word
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic [BG_W-1:0]   background;
    logic [MODE_W-1:0] mode_level;
    logic              updated;
  } bg_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mbm_in_if  in_ch ();
  mbm_out_if out_ch ();

  mode_background_model_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor state, mirrors the block after reset
  bit [CNT_W-1:0] hist_q [MBM_POSITIONS*MBM_MAX_LEVELS];
  bit [3:0]       ring_q [MBM_MAX_FRAMES*MBM_POSITIONS];
  bit [BG_W-1:0]  bg_q [MBM_POSITIONS];
  bit             bg_known [MBM_POSITIONS];
  int unsigned    known_pos [$];
  bit [LC_W-1:0]  lc_reg = 5'd16;
  bit [HF_W-1:0]  hf_reg = 6'd32;
  bit [UI_W-1:0]  ui_reg = 8'd1;
  int unsigned    fsu = 1;
  int unsigned    ring_slot = 0;
  bit             in_frame = 1'b0;
  bit             frame_upd = 1'b0;

  bg_result_t  bg_expect_q [$];
  bg_result_t  head_w;
  int          fail_count = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          rx_hold_req = 0;
  int          rx_hold_left = 0;
  int unsigned hot_pos [12];
  bit [7:0]    hot_center [12];

  // Decision the next word would take: current frame's, or the one made at frame start
  function automatic bit next_frame_updates();
    int unsigned iv;
    if (in_frame) return frame_upd;
    iv = (ui_reg == 0) ? 1 : ui_reg;
    return fsu >= iv;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_LEVEL_COUNT:     lc_reg = val[LC_W-1:0];
      CFG_HISTORY_FRAMES:  hf_reg = val[HF_W-1:0];
      CFG_UPDATE_INTERVAL: begin
        ui_reg = val[UI_W-1:0];
        fsu = ui_reg;
      end
      default: ;
    endcase
  endfunction

  // Background estimate for one accepted word; advances the mirrored state
  function automatic bg_result_t estimate_background(input bit [7:0] smp, input bit [13:0] pos_in,
                                                     input bit last);
    int unsigned pos, lv, base, ring_idx, old_lv, q, m, hist;
    bg_result_t r;
    pos = pos_in % MBM_POSITIONS;
    lv = (lc_reg < 2) ? 2 : (lc_reg > MBM_MAX_LEVELS) ? MBM_MAX_LEVELS : lc_reg;
    base = pos * MBM_MAX_LEVELS;
    if (!in_frame) begin
      frame_upd = next_frame_updates();
      if (frame_upd) fsu = 0;
      in_frame = 1'b1;
    end
    if (frame_upd) begin
      ring_idx = (ring_slot % MBM_MAX_FRAMES) * MBM_POSITIONS + pos;
      old_lv = ring_q[ring_idx];
      if (hist_q[base+old_lv] != 0) hist_q[base+old_lv] = hist_q[base+old_lv] - 1'b1;
      q = (2 * smp * (lv - 1) + 255) / 510;
      if (q > lv - 1) q = lv - 1;
      ring_q[ring_idx] = 4'(q);
      if (hist_q[base+q] < COUNT_MAX) hist_q[base+q] = hist_q[base+q] + 1'b1;
    end
    // lowest bin wins ties
    m = 0;
    for (int i = 1; i < lv; i++) begin
      if (hist_q[base+i] > hist_q[base+m]) m = i;
    end
    if (frame_upd) begin
      bg_q[pos] = BG_W'((510 * m + (lv - 1)) / (2 * (lv - 1)));
      if (!bg_known[pos]) begin
        bg_known[pos] = 1'b1;
        known_pos.push_back(pos);
      end
    end
    r.background = bg_q[pos];
    r.mode_level = MODE_W'(m);
    r.updated    = frame_upd;
    if (last) begin
      if (frame_upd) begin
        hist = (hf_reg < 1) ? 1 : (hf_reg > MBM_MAX_FRAMES) ? MBM_MAX_FRAMES : hf_reg;
        ring_slot++;
        if (ring_slot >= hist) ring_slot = 0;
      end
      if (fsu < FSU_MAX) fsu++;
      in_frame = 1'b0;
    end
    return r;
  endfunction

  // Offer one word; returns right after the accepting edge
  task automatic send_sample(input bit [7:0] smp, input bit [13:0] pos, input bit last);
    @(negedge clk);
    while (tx_idle_en && $urandom_range(99) < 7) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.sample     = smp;
    in_ch.position   = pos;
    in_ch.frame_last = last;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    bg_expect_q.push_back(estimate_background(smp, pos, last));
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (bg_expect_q.size() != 0) @(posedge clk);
  endtask

  // Register writes only once the block has gone idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_results_done();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    apply_reg_write(idx, val);
  endtask

  // One complete frame; skipped frames only touch positions with a stored background
  task automatic send_frame(input int unsigned len);
    bit upd;
    int unsigned h, c, pos;
    int v;
    bit [7:0] smp;
    upd = next_frame_updates();
    for (int k = 0; k < len; k++) begin
      h = $urandom_range(11);
      c = $urandom_range(99);
      if (!upd || c < 10) begin
        pos = known_pos[$urandom_range(known_pos.size() - 1)];
        smp = 8'($urandom_range(255));
      end else if (c < 18) begin
        pos = $urandom_range(16383);
        smp = 8'($urandom_range(255));
      end else begin
        pos = hot_pos[h];
        if ($urandom_range(3) == 0) begin
          smp = 8'($urandom_range(255));
        end else begin
          v = int'(hot_center[h]) + int'($urandom_range(24)) - 12;
          smp = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
        end
      end
      send_sample(smp, 14'(pos), k == len - 1);
    end
  endtask

  // One random phase under one register setting
  task automatic run_frames(input logic [7:0] lc_val, input logic [7:0] hf_val,
                            input logic [7:0] iv_val, input int unsigned n_items,
                            input int unsigned max_len, input int unsigned hold_at,
                            input int unsigned pause_at);
    int unsigned sent;
    int unsigned len;
    bit held, paused;
    sent = 0;
    held = 1'b0;
    paused = 1'b0;
    write_reg(CFG_LEVEL_COUNT, lc_val);
    write_reg(CFG_HISTORY_FRAMES, hf_val);
    write_reg(CFG_UPDATE_INTERVAL, iv_val);
    for (int i = 0; i < 3; i++) hot_center[$urandom_range(11)] = 8'($urandom_range(255));
    while (sent < n_items) begin
      len = $urandom_range(max_len, 1);
      send_frame(len);
      sent += len;
      if (hold_at != 0 && sent >= hold_at && !held) begin
        rx_hold_req = HOLD_CYCLES;
        held = 1'b1;
      end
      if (pause_at != 0 && sent >= pause_at && !paused) begin
        wait_results_done();
        paused = 1'b1;
      end
    end
  endtask

  // Defaults after reset; first frame removes from empty bins, second ties
  task automatic test_first_frames();
    send_sample(8'd0,   14'd0,      1'b0);
    send_sample(8'd255, 14'd16383,  1'b0);
    send_sample(8'd128, 14'h2AAA,   1'b0);
    send_sample(8'd127, 14'h1555,   1'b1);
    send_sample(8'd255, 14'd0,      1'b0);
    send_sample(8'd0,   14'd16383,  1'b0);
    send_sample(8'd17,  14'h2AAA,   1'b0);
    send_sample(8'd238, 14'h1555,   1'b1);
  endtask

  // Interval write reloads the frame counter; zero interval skips once, then acts as 1
  task automatic test_update_interval();
    write_reg(CFG_UPDATE_INTERVAL, 8'd3);
    send_sample(8'd200, 14'd0,     1'b1);
    send_sample(8'd90,  14'd16383, 1'b1);
    send_sample(8'd10,  14'h2AAA,  1'b1);
    send_sample(8'd201, 14'd0,     1'b1);
    write_reg(CFG_UPDATE_INTERVAL, 8'd0);
    send_sample(8'd50,  14'd0,     1'b1);
    send_sample(8'd51,  14'd0,     1'b1);
  endtask

  // Level count at its floor, below it, above it and just past the top
  task automatic test_level_count();
    write_reg(CFG_UPDATE_INTERVAL, 8'd1);
    write_reg(CFG_LEVEL_COUNT, 8'd2);
    send_sample(8'd127, 14'h1555,  1'b0);
    send_sample(8'd128, 14'd0,     1'b1);
    write_reg(CFG_LEVEL_COUNT, 8'd0);
    send_sample(8'd255, 14'd16383, 1'b1);
    write_reg(CFG_LEVEL_COUNT, 8'd31);
    send_sample(8'd200, 14'h2AAA,  1'b1);
    write_reg(CFG_LEVEL_COUNT, 8'd17);
    send_sample(8'd64,  14'd0,     1'b1);
  endtask

  // Ring length of one, zero (acts as one) and past the top
  task automatic test_history_length();
    write_reg(CFG_HISTORY_FRAMES, 8'd1);
    send_sample(8'd90,  14'h1555, 1'b1);
    send_sample(8'd180, 14'h1555, 1'b1);
    write_reg(CFG_HISTORY_FRAMES, 8'd0);
    send_sample(8'd30,  14'h1555, 1'b1);
    write_reg(CFG_HISTORY_FRAMES, 8'd63);
    send_sample(8'd250, 14'h1555, 1'b1);
  endtask

  // A write to the unused index must change nothing
  task automatic test_spare_index();
    write_reg(CFG_SPARE_IDX, 8'hFF);
    send_sample(8'd1, 14'd0, 1'b1);
  endtask

  task automatic test_random_default();
    run_frames(8'd16, 8'd32, 8'd1, 150, 8, 0, 0);
  endtask

  task automatic test_coarse_levels();
    run_frames(8'd2, 8'd1, 8'd1, 120, 4, 0, 0);
  endtask

  task automatic test_output_stall();
    run_frames(8'd5, 8'd7, 8'd2, 150, 6, 40, 0);
  endtask

  task automatic test_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_frames(8'($urandom_range(16, 2)), 8'($urandom_range(32, 1)), 8'd3, 150, 8, 0, 0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Upper register bits masked away, then clamped
  task automatic test_wide_reg_values();
    run_frames(8'hFF, 8'hFF, 8'd1, 120, 8, 0, 0);
  endtask

  task automatic test_long_interval();
    run_frames(8'd9, 8'd32, 8'd255, 260, 1, 0, 0);
  endtask

  task automatic test_sender_pause();
    run_frames(8'($urandom_range(16, 2)), 8'($urandom_range(32, 1)),
               8'($urandom_range(4, 1)), 130, 8, 0, 60);
  endtask

  // Receiver: random idling, plus a long hold-off counted here
  always @(negedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left != 0) begin
      out_ch.ready = 1'b0;
      rx_hold_left--;
    end else begin
      out_ch.ready = !(rx_idle_en && $urandom_range(99) < 7);
    end
  end

  // Result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (bg_expect_q.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        head_w = bg_expect_q.pop_front();
        if (out_ch.background !== head_w.background) begin
          $error("background: expected %0d, actual %0d", head_w.background, out_ch.background);
          fail_count++;
        end
        if (out_ch.mode_level !== head_w.mode_level) begin
          $error("mode_level: expected %0d, actual %0d", head_w.mode_level, out_ch.mode_level);
          fail_count++;
        end
        if (out_ch.updated !== head_w.updated) begin
          $error("updated: expected %0d, actual %0d", head_w.updated, out_ch.updated);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.position = '0;
    in_ch.frame_last = 1'b0;
    out_ch.ready = 1'b0;
    hot_pos[0] = 0;
    hot_pos[1] = 16383;
    hot_pos[2] = 14'h2AAA;
    hot_pos[3] = 14'h1555;
    for (int i = 4; i < 12; i++) hot_pos[i] = $urandom_range(16383);
    for (int i = 0; i < 12; i++) hot_center[i] = 8'($urandom_range(255));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // clearing pass holds in_ch.ready low; the first send just waits it out
    test_first_frames();
    test_update_interval();
    test_level_count();
    test_history_length();
    test_spare_index();
    test_random_default();
    test_coarse_levels();
    test_output_stall();
    test_no_idle();
    test_wide_reg_values();
    test_long_interval();
    test_sender_pause();

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
